// ===== rtl/ookps_pkg.sv =====
`default_nettype none

package ookps_pkg;

  localparam int unsigned NumWidth    = 10;
  localparam int unsigned QuotWidth   = 7;   // 1023 / 10 = 102
  localparam int unsigned FrameWidth  = 36;
  localparam int unsigned BitIdxWidth = 6;
  localparam int unsigned ChipIdxWidth = 8;

  localparam logic [ChipIdxWidth-1:0] DataChips  = 8'd144;
  localparam logic [ChipIdxWidth-1:0] FrameLast  = 8'd171;
  localparam logic [7:0]              RepeatReset = 8'd30;

  localparam logic [1:0] PosOn  = 2'd0;
  localparam logic [1:0] PosOff = 2'd3;

  localparam logic FuncStart = 1'b0;
  localparam logic FuncTick  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_START = 3'b010,
    PH_BIT   = 3'b100
  } phase_t;

  // One input item after the first divide-by-ten step.
  typedef struct packed {
    logic                 func;
    logic [QuotWidth-1:0] sys_q;
    logic [3:0]           sys_d0;
    logic [QuotWidth-1:0] pg_q;
    logic [3:0]           pg_d0;
    logic [3:0]           alert;
  } in_item_t;

  // v / 10 as (v * 205) >> 11, exact for v < 1029.
  function automatic logic [QuotWidth-1:0] div10(input logic [NumWidth-1:0] v);
    logic [17:0] p;
    p = {8'd0, v} * 18'd205;
    return p[17:11];
  endfunction

  // v - 10*q, with q = v / 10.
  function automatic logic [3:0] rem10(input logic [NumWidth-1:0] v,
                                       input logic [QuotWidth-1:0] q);
    logic [NumWidth-1:0] t;
    t = v - {q, 3'b000} - {2'b00, q, 1'b0};
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ookps_in_stage.sv =====
`default_nettype none

module ookps_in_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_func,
  input  wire logic [9:0]          in_sys_num,
  input  wire logic [9:0]          in_pager_num,
  input  wire logic [3:0]          in_alert_kind,
  output logic                     item_valid,
  input  wire logic                item_ready,
  output ookps_pkg::in_item_t      item
);
  import ookps_pkg::*;

  in_item_t item_next;

  assign in_ready = !item_valid || item_ready;

  // First decimal step: ones digit and quotient for both numbers.
  always_comb begin
    item_next.func   = in_func;
    item_next.sys_q  = div10(in_sys_num);
    item_next.sys_d0 = rem10(in_sys_num, item_next.sys_q);
    item_next.pg_q   = div10(in_pager_num);
    item_next.pg_d0  = rem10(in_pager_num, item_next.pg_q);
    item_next.alert  = in_alert_kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ookps_seq.sv =====
`default_nettype none

module ookps_seq (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire ookps_pkg::in_item_t item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_chip,
  output logic                     out_sending,
  output logic                     out_done
);
  import ookps_pkg::*;

  logic [7:0]              repeat_count;
  phase_t                  phase, phase_next;
  logic [FrameWidth-1:0]   frame_bits, frame_bits_next;
  logic [ChipIdxWidth-1:0] chip_index, chip_index_next;
  logic [7:0]              repeats_left, repeats_left_next;
  logic                    chip_next, sending_next, done_next;
  logic                    advance;

  logic [QuotWidth-1:0] sys_q2, pg_q2;
  logic [3:0]           sys_d1, sys_d2, pg_d1, pg_d2;
  logic [1:0]           pos;
  logic                 data_bit;

  assign item_ready = !out_valid || out_ready;
  assign advance    = item_valid && item_ready;

  // Second decimal step: tens and hundreds.
  always_comb begin
    sys_q2 = div10({3'b000, item.sys_q});
    sys_d1 = rem10({3'b000, item.sys_q}, sys_q2);
    sys_d2 = (sys_q2 >= 7'd10) ? 4'd0 : sys_q2[3:0];
    pg_q2  = div10({3'b000, item.pg_q});
    pg_d1  = rem10({3'b000, item.pg_q}, pg_q2);
    pg_d2  = (pg_q2 >= 7'd10) ? 4'd0 : pg_q2[3:0];
  end

  assign pos      = chip_index[1:0];
  assign data_bit = frame_bits[chip_index[BitIdxWidth+1:2]];

  always_comb begin
    phase_next        = phase;
    frame_bits_next   = frame_bits;
    chip_index_next   = chip_index;
    repeats_left_next = repeats_left;
    chip_next         = 1'b0;
    sending_next      = 1'b0;
    done_next         = 1'b0;
    if (item.func == FuncStart) begin
      frame_bits_next   = {8'h00, sys_d2, sys_d1, item.sys_d0, item.alert,
                           pg_d2, pg_d1, item.pg_d0};
      repeats_left_next = (repeat_count == 8'd0) ? 8'd1 : repeat_count;
      chip_index_next   = '0;
      phase_next        = PH_START;
    end else begin
      case (phase)
        PH_START: begin
          phase_next      = PH_BIT;
          chip_index_next = '0;
        end
        PH_BIT: begin
          sending_next = 1'b1;
          if (chip_index < DataChips) begin
            if (pos == PosOn) begin
              chip_next = 1'b1;
            end else if (pos != PosOff) begin
              chip_next = data_bit;
            end
          end
          if (chip_index == FrameLast) begin
            chip_index_next   = '0;
            repeats_left_next = repeats_left - 8'd1;
            if (repeats_left == 8'd1) begin
              phase_next = PH_IDLE;
              done_next  = 1'b1;
            end
          end else begin
            chip_index_next = chip_index + 8'd1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count <= RepeatReset;
    end else if (cfg_wr_en) begin
      repeat_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frame_bits   <= '0;
      chip_index   <= '0;
      repeats_left <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      frame_bits   <= frame_bits_next;
      chip_index   <= chip_index_next;
      repeats_left <= repeats_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_chip    <= chip_next;
      out_sending <= sending_next;
      out_done    <= done_next;
    end
  end

`ifndef SYNTHESIS
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    advance && done_next |=> phase == PH_IDLE)
    else $error("done without return to idle");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> chip_index == '0)
    else $error("chip index not cleared in idle");

  a_bit_has_repeats: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BIT |-> repeats_left != 8'd0 && chip_index <= FrameLast)
    else $error("sending with no repeats left or index out of frame");

  a_chip_needs_sending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_sending |-> !out_chip && !out_done)
    else $error("chip or done set on a silent result");
`endif

endmodule

`default_nettype wire

// ===== rtl/ook_pager_frame_chip_sender.sv =====
// A transaction passes two register stages (input item, then result) before m_axis.
// Throughput: one transaction per cycle; both register stages stall only on m_axis_tready.
// Reset (rst, synchronous, active high): idle, frame and counters cleared, repeat count 30,
// both stages empty.
`default_nettype none

module ook_pager_frame_chip_sender (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: repeat count, written whenever cfg_wr_en is high
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [9:0] sys_num, [19:10] pager_num,
                                          // [23:20] alert_kind
  input  wire logic        s_axis_tuser,  // [0] func: 0 start, 1 tick
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] chip, [7:1] zero
  output logic             m_axis_tuser,  // [0] sending
  output logic             m_axis_tlast   // done_res: last chip of final repeat
);
  import ookps_pkg::*;

  // Stage 1 registers the item and does the first divide-by-ten on both
  // numbers (ones digit and quotient). Stage 2 finishes the BCD digits,
  // runs the frame sequencer and loads the result register. Each stage
  // takes a new transaction whenever its own register is empty or being
  // drained, so a waiting result stalls the input only once both stage
  // registers are full.
  logic     item_valid;
  logic     item_ready;
  in_item_t item;
  logic     out_chip;

  ookps_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_func       (s_axis_tuser),
    .in_sys_num    (s_axis_tdata[9:0]),
    .in_pager_num  (s_axis_tdata[19:10]),
    .in_alert_kind (s_axis_tdata[23:20]),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item)
  );

  // Sequencer: start loads the 36-bit frame and repeat count; the first tick
  // arms it; each later tick emits one chip (1110 / 1000 per bit, LSB first,
  // then 28 off chips), 172 chips per frame, repeated then back to idle.
  ookps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_chip    (out_chip),
    .out_sending (m_axis_tuser),
    .out_done    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_chip};

endmodule

`default_nettype wire
